>>> hdl/sfpp_pkg.sv
// shared types and constants for the sync-framed packet parser
`timescale 1ns / 1ps

package sfpp_pkg;

	localparam int unsigned MAX_PAYLOAD_DEFAULT = 255;

	localparam logic [7:0] FIRST_SYNC_RESET  = 8'hEE;
	localparam logic [7:0] SECOND_SYNC_RESET = 8'hFE;

	typedef enum logic [3:0] {
		PH_HUNT    = 4'd0,
		PH_SYNC1   = 4'd1,
		PH_SYNC2   = 4'd2,
		PH_ID      = 4'd3,
		PH_TS0     = 4'd4,
		PH_TS1     = 4'd5,
		PH_TS2     = 4'd6,
		PH_TS3     = 4'd7,
		PH_PAYLOAD = 4'd8,
		PH_CHECK   = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_SYNC2 = 2'd1,
		ERR_BUSY  = 2'd2,
		ERR_CSUM  = 2'd3
	} err_t;

	typedef enum logic {
		REG_FIRST_SYNC  = 1'b0,
		REG_SECOND_SYNC = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic       frame_good;
		logic [7:0] message_id;
		logic [7:0] frame_length;
		err_t       error_code;
		logic [7:0] error_total;
	} res_t;

endpackage

>>> hdl/sfpp_deframer.sv
// parse state machine: frame state, running checksum and error tally
`timescale 1ns / 1ps

module sfpp_deframer import sfpp_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       sink_busy,
	input  logic [7:0] first_sync,
	input  logic [7:0] second_sync,
	output res_t       res
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	phase_t     phase_q, phase_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] id_q, id_d;
	logic [7:0] len_q, len_d;
	logic [7:0] idx_q, idx_d;
	logic [7:0] tally_q, tally_d;
	err_t       err;
	logic [7:0] len_sat;
	logic [7:0] idx_inc;

	assign len_sat = (data_byte > MAX_LEN) ? MAX_LEN : data_byte;
	assign idx_inc = idx_q + 8'd1;

	always_comb begin
		err = ERR_NONE;
		case (phase_q)
			PH_SYNC1: begin
				if (data_byte != second_sync)
					err = ERR_SYNC2;
			end
			PH_SYNC2: begin
				if (sink_busy)
					err = ERR_BUSY;
			end
			PH_CHECK: begin
				if (sum_q != data_byte)
					err = ERR_CSUM;
			end
			default: err = ERR_NONE;
		endcase
	end

	// next phase
	always_comb begin
		phase_d = PH_HUNT;
		case (phase_q)
			PH_HUNT:    phase_d = (data_byte == first_sync) ? PH_SYNC1 : PH_HUNT;
			PH_SYNC1:   phase_d = PH_SYNC2;
			PH_SYNC2:   phase_d = PH_ID;
			PH_ID, PH_TS0, PH_TS1, PH_TS2:
				phase_d = phase_t'(4'(phase_q + 4'd1));
			PH_TS3:     phase_d = (len_sat == 8'd0) ? PH_CHECK : PH_PAYLOAD;
			PH_PAYLOAD: phase_d = (idx_inc >= len_q) ? PH_CHECK : PH_PAYLOAD;
			PH_CHECK:   phase_d = PH_HUNT;
			default:    phase_d = PH_HUNT;
		endcase
		if (err != ERR_NONE)
			phase_d = PH_HUNT;
	end

	// datapath and result
	always_comb begin
		sum_d   = sum_q;
		id_d    = id_q;
		len_d   = len_q;
		idx_d   = idx_q;
		tally_d = (err != ERR_NONE) ? tally_q + 8'd1 : tally_q;
		res     = '0;
		case (phase_q)
			PH_HUNT:  sum_d = data_byte;
			PH_SYNC1: sum_d = sum_q + data_byte;
			PH_SYNC2: begin
				if (!sink_busy) begin
					id_d  = data_byte;
					sum_d = sum_q + data_byte;
				end
			end
			PH_ID, PH_TS0, PH_TS1, PH_TS2: sum_d = sum_q + data_byte;
			PH_TS3: begin
				sum_d = sum_q + data_byte;
				len_d = len_sat;
				idx_d = 8'd0;
			end
			PH_PAYLOAD: begin
				sum_d             = sum_q + data_byte;
				idx_d             = idx_inc;
				res.payload_valid = 1'b1;
				res.payload_byte  = data_byte;
				res.payload_index = idx_q;
			end
			PH_CHECK: res.frame_good = (sum_q == data_byte);
			default: sum_d = sum_q;
		endcase
		res.message_id   = id_d;
		res.frame_length = len_d;
		res.error_code   = err;
		res.error_total  = tally_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sum_q   <= '0;
			id_q    <= '0;
			len_q   <= '0;
			idx_q   <= '0;
			tally_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			id_q    <= id_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
			tally_q <= tally_d;
		end
	end

`ifndef SYNTHESIS
	a_tally_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		step && err != ERR_NONE |=> tally_q == 8'($past(tally_q) + 8'd1))
		else $error("error tally did not advance on a dropped frame");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(sum_q) && $stable(tally_q))
		else $error("parse state moved without an item");

	a_payload_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> idx_q < len_q)
		else $error("payload index ran past the frame length");
`endif

endmodule

>>> hdl/sync_framed_packet_parser.sv
// Sync-framed packet parser: deframes a byte stream (two sync bytes, id, four
// timestamp bytes, length, payload, additive checksum), one byte per item and
// one result per item. An item is registered at the input, parsed by a single
// level of state-machine logic and an 8-bit add, and the result is registered
// at the output. A new byte is taken every cycle while the output is not stalled.
// Payload bytes stream out as they arrive; keep them only if the checksum result
// reports frame_good.
`timescale 1ns / 1ps

module sync_framed_packet_parser import sfpp_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       sink_busy,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       payload_valid,
	output logic [7:0] payload_byte,
	output logic [7:0] payload_index,
	output logic       frame_good,
	output logic [7:0] message_id,
	output logic [7:0] frame_length,
	output logic [1:0] error_code,
	output logic [7:0] error_total
);

	logic [7:0] first_sync_q;
	logic [7:0] second_sync_q;
	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       sink_busy_s1;
	logic       valid_s2;
	res_t       res_s2;
	res_t       res;
	logic       advance;
	logic       step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sync_q  <= FIRST_SYNC_RESET;
			second_sync_q <= SECOND_SYNC_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FIRST_SYNC:  first_sync_q  <= cfg_wdata;
				REG_SECOND_SYNC: second_sync_q <= cfg_wdata;
				default:         first_sync_q  <= first_sync_q;
			endcase
		end
	end

	// output register frees up when empty or being taken
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_byte_s1 <= data_byte;
			sink_busy_s1 <= sink_busy;
		end
		if (step)
			res_s2 <= res;
	end

	sfpp_deframer #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_deframer (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.data_byte   (data_byte_s1),
		.sink_busy   (sink_busy_s1),
		.first_sync  (first_sync_q),
		.second_sync (second_sync_q),
		.res         (res)
	);

	assign out_valid     = valid_s2;
	assign payload_valid = res_s2.payload_valid;
	assign payload_byte  = res_s2.payload_byte;
	assign payload_index = res_s2.payload_index;
	assign frame_good    = res_s2.frame_good;
	assign message_id    = res_s2.message_id;
	assign frame_length  = res_s2.frame_length;
	assign error_code    = res_s2.error_code;
	assign error_total   = res_s2.error_total;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with room in the pipeline");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.error_code != ERR_NONE |-> !res_s2.payload_valid && !res_s2.frame_good)
		else $error("error result also flags payload or good frame");

	a_item_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("parsed item lost before the output register");
`endif

endmodule

>>> test/tb_sync_framed_packet_parser.sv
// testbench for the sync-framed packet parser: framed byte streams, per-byte result check
`timescale 1ns / 1ps

module tb_sync_framed_packet_parser;
	import sfpp_pkg::*;

	localparam int LEN_CAP = MAX_PAYLOAD_DEFAULT;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int BYTES_PER_PHASE = 241;

	typedef enum int {
		FAULT_NONE,
		FAULT_SYNC2,
		FAULT_BUSY,
		FAULT_CSUM
	} frame_fault_t;

	class frame_checker;
		res_t due_results[$];
		int unsigned fail_count;
		logic [7:0] first_sync, second_sync;
		phase_t phase;
		logic [7:0] sum, fid, flen, idx, tally;

		function new();
			first_sync = FIRST_SYNC_RESET;
			second_sync = SECOND_SYNC_RESET;
			phase = PH_HUNT;
			sum = 8'd0;
			fid = 8'd0;
			flen = 8'd0;
			idx = 8'd0;
			tally = 8'd0;
			fail_count = 0;
		endfunction

		function void set_reg(cfg_reg_t r, logic [7:0] v);
			if (r == REG_FIRST_SYNC) begin
				first_sync = v;
			end else begin
				second_sync = v;
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// advance the parser state by one byte and queue what it should report
		function void note_byte(logic [7:0] c, logic busy);
			res_t r;
			r = '0;
			r.error_code = ERR_NONE;
			case (phase)
				PH_HUNT: begin
					sum = c;
					if (c == first_sync) begin
						phase = PH_SYNC1;
					end
				end
				PH_SYNC1: begin
					sum = sum + c;
					if (c != second_sync) begin
						r.error_code = ERR_SYNC2;
					end else begin
						phase = PH_SYNC2;
					end
				end
				PH_SYNC2: begin
					if (busy) begin
						r.error_code = ERR_BUSY;
					end else begin
						fid = c;
						sum = sum + c;
						phase = PH_ID;
					end
				end
				PH_ID, PH_TS0, PH_TS1, PH_TS2: begin
					sum = sum + c;
					phase = phase_t'(phase + 4'd1);
				end
				PH_TS3: begin
					sum = sum + c;
					flen = (int'(c) > LEN_CAP) ? 8'(LEN_CAP) : c;
					idx = 8'd0;
					phase = (flen == 8'd0) ? PH_CHECK : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					sum = sum + c;
					r.payload_valid = 1'b1;
					r.payload_byte = c;
					r.payload_index = idx;
					idx = idx + 8'd1;
					if (idx >= flen) begin
						phase = PH_CHECK;
					end
				end
				PH_CHECK: begin
					if (sum == c) begin
						r.frame_good = 1'b1;
						phase = PH_HUNT;
					end else begin
						r.error_code = ERR_CSUM;
					end
				end
				default: begin
					phase = PH_HUNT;
				end
			endcase
			if (r.error_code != ERR_NONE) begin
				tally = tally + 8'd1;
				phase = PH_HUNT;
			end
			r.message_id = fid;
			r.frame_length = flen;
			r.error_total = tally;
			due_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				fail_count++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (due_results.size() == 0) begin
				$error("result item arrived with nothing outstanding");
				fail_count++;
			end else begin
				want = due_results.pop_front();
				compare_field("payload_valid", want.payload_valid, got.payload_valid);
				compare_field("payload_byte", want.payload_byte, got.payload_byte);
				compare_field("payload_index", want.payload_index, got.payload_index);
				compare_field("frame_good", want.frame_good, got.frame_good);
				compare_field("message_id", want.message_id, got.message_id);
				compare_field("frame_length", want.frame_length, got.frame_length);
				compare_field("error_code", want.error_code, got.error_code);
				compare_field("error_total", want.error_total, got.error_total);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	cfg_reg_t   cfg_index;
	logic [7:0] cfg_wdata;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       sink_busy;
	logic       out_valid;
	logic       out_stall;
	logic       payload_valid;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic       frame_good;
	logic [7:0] message_id;
	logic [7:0] frame_length;
	logic [1:0] error_code;
	logic [7:0] error_total;

	frame_checker sb;
	int unsigned send_pct;
	int unsigned recv_pct;
	int unsigned frame_bytes;
	int unsigned quiet_cycles;

	sync_framed_packet_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.sink_busy(sink_busy),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.payload_valid(payload_valid),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.frame_good(frame_good),
		.message_id(message_id),
		.frame_length(frame_length),
		.error_code(error_code),
		.error_total(error_total)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.payload_valid = payload_valid;
			got.payload_byte = payload_byte;
			got.payload_index = payload_index;
			got.frame_good = frame_good;
			got.message_id = message_id;
			got.frame_length = frame_length;
			got.error_code = err_t'(error_code);
			got.error_total = error_total;
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// present one byte, hold it until taken, return at the next falling edge
	task automatic push_byte(input logic [7:0] d, input logic b);
		while (send_pct != 0 && $urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		sink_busy <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_byte(d, b);
		@(negedge clk);
	endtask

	task automatic send_frame(input frame_fault_t fault, input int unsigned len);
		logic [7:0] s;
		logic [7:0] b;
		int unsigned i;
		s = sb.first_sync;
		push_byte(sb.first_sync, 1'($urandom_range(1)));
		b = sb.second_sync;
		if (fault == FAULT_SYNC2) begin
			b = b ^ 8'($urandom_range(1, 255));
		end
		s = s + b;
		push_byte(b, 1'($urandom_range(1)));
		frame_bytes += 2;
		if (fault == FAULT_SYNC2) begin
			return;
		end
		b = 8'($urandom_range(255));
		push_byte(b, fault == FAULT_BUSY);
		frame_bytes++;
		if (fault == FAULT_BUSY) begin
			return;
		end
		s = s + b;
		// four timestamp bytes, then the length
		for (i = 0; i < 5; i++) begin
			b = (i == 4) ? 8'(len) : 8'($urandom_range(255));
			s = s + b;
			push_byte(b, 1'($urandom_range(1)));
		end
		for (i = 0; i < len; i++) begin
			b = 8'($urandom_range(255));
			s = s + b;
			push_byte(b, 1'($urandom_range(1)));
		end
		if (fault == FAULT_CSUM) begin
			s = s ^ 8'($urandom_range(1, 255));
		end
		push_byte(s, 1'($urandom_range(1)));
		frame_bytes += 6 + len;
	endtask

	task automatic send_random_frame();
		int unsigned r;
		int unsigned q;
		int unsigned len;
		frame_fault_t fault;
		r = $urandom_range(99);
		if (r < 5) begin
			fault = FAULT_SYNC2;
		end else if (r < 10) begin
			fault = FAULT_BUSY;
		end else if (r < 20) begin
			fault = FAULT_CSUM;
		end else begin
			fault = FAULT_NONE;
		end
		q = $urandom_range(99);
		if (q < 80) begin
			len = $urandom_range(6);
		end else if (q < 97) begin
			len = $urandom_range(7, 40);
		end else begin
			len = $urandom_range(1) ? 255 : $urandom_range(200, 254);
		end
		send_frame(fault, len);
	endtask

	task automatic drain();
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// both sync registers, written back to back while the parser is idle
	task automatic write_syncs(input logic [7:0] first_v, input logic [7:0] second_v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_FIRST_SYNC;
		cfg_wdata <= first_v;
		sb.set_reg(REG_FIRST_SYNC, first_v);
		@(negedge clk);
		cfg_index <= REG_SECOND_SYNC;
		cfg_wdata <= second_v;
		sb.set_reg(REG_SECOND_SYNC, second_v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [7:0] first_tab [PHASES];
		logic [7:0] second_tab [PHASES];
		int p;
		int k;
		first_tab = '{8'hEE, 8'h00, 8'hFF, 8'h00, 8'h5A, 8'hEE, 8'hFF, 8'h00};
		second_tab = '{8'hFE, 8'hFF, 8'h00, 8'h00, 8'h5A, 8'hFE, 8'hFF, 8'h00};
		sb = new();
		send_pct = 0;
		recv_pct = 0;
		frame_bytes = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FIRST_SYNC;
		cfg_wdata = 8'd0;
		in_valid = 1'b0;
		data_byte = 8'd0;
		sink_busy = 1'b0;
		out_stall = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: ignored bytes, a good frame, each error, the first sync not rescanned
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		send_frame(FAULT_NONE, 1);
		push_byte(sb.first_sync, 1'b0);
		push_byte(sb.first_sync, 1'b1);
		send_frame(FAULT_BUSY, 0);
		send_frame(FAULT_CSUM, 0);
		in_valid <= 1'b0;
		drain();

		for (p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin send_pct = 0;  recv_pct = 0;  end
				1: begin send_pct = 78; recv_pct = 0;  end
				2: begin send_pct = 0;  recv_pct = 78; end
				default: begin send_pct = 38; recv_pct = 38; end
			endcase
			if (p == 3) begin
				write_syncs(8'($urandom_range(255)), 8'($urandom_range(255)));
			end else if (p != 0) begin
				write_syncs(first_tab[p], second_tab[p]);
			end
			@(negedge clk);
			while (frame_bytes < 25 + (p + 1) * BYTES_PER_PHASE) begin
				// stray bytes between frames now and then
				if ($urandom_range(99) < 30) begin
					for (k = $urandom_range(1, 3); k > 0; k--) begin
						push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
					end
				end
				send_random_frame();
			end
			in_valid <= 1'b0;
			drain();
		end

		repeat (10) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/sfpp_pkg.sv
hdl/sfpp_deframer.sv
hdl/sync_framed_packet_parser.sv
test/tb_sync_framed_packet_parser.sv
